// ===== hdl/pcld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcld_pkg;

   // widths of the sample path and the gain format
   localparam int SAMPLE_BITS    = 16;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int GAIN_W         = 32;
   localparam int CODE_W         = 16;
   localparam int ERR_BITS       = SAMPLE_BITS + 1;
   localparam int DIFF_W         = ((SAMPLE_BITS > CODE_W) ? SAMPLE_BITS : CODE_W) + 1;
   localparam int DD_W           = DIFF_W + 1;
   localparam int PROD_W         = GAIN_W + DIFF_W;
   localparam int DPROD_W        = GAIN_W + DD_W;
   localparam int ACC_W          = CODE_W + 1 + GAIN_FRAC_BITS;
   localparam int ISUM_W         = PROD_W + 1;
   localparam int SUM_W          = PROD_W + 3;
   localparam int SQ_W           = 2 * DIFF_W;
   localparam int SSUM_W         = 63;
   localparam int CNT_W          = 32;

   // configuration port
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 3;
   localparam int ADDR_W  = IDX_W + 2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // statistics start values
   localparam logic signed [DIFF_W-1:0] PEAK_HI_INIT = -(DIFF_W'(1) << (ERR_BITS - 1));
   localparam logic signed [DIFF_W-1:0] PEAK_LO_INIT =
      (DIFF_W'(1) << (ERR_BITS - 1)) - DIFF_W'(1);
   localparam logic signed [SUM_W-1:0]  ROUND_HALF   = SUM_W'(1) << (GAIN_FRAC_BITS - 1);

   typedef enum logic [IDX_W-1:0] {
      REG_P_GAIN      = 3'd0,
      REG_KI_GAIN     = 3'd1,
      REG_KD_GAIN     = 3'd2,
      REG_TARGET      = 3'd3,
      REG_OFFSET      = 3'd4,
      REG_LOCK_WINDOW = 3'd5,
      REG_RAILS       = 3'd6,
      REG_INT_LIMITS  = 3'd7
   } reg_index_type;

   // item classes decided by the front
   typedef enum logic [1:0] {
      OP_IDLE    = 2'd0,
      OP_RUN     = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] p_gain;
      logic signed [GAIN_W-1:0] ki_gain;
      logic signed [GAIN_W-1:0] kd_gain;
      logic signed [CODE_W-1:0] target_code;
      logic signed [CODE_W-1:0] drive_offset;
      logic        [CODE_W-1:0] lock_window;
      logic signed [CODE_W-1:0] rail_min;
      logic signed [CODE_W-1:0] rail_max;
      logic signed [CODE_W-1:0] int_min;
      logic signed [CODE_W-1:0] int_max;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      p_gain:       32'sd65536,
      ki_gain:      '0,
      kd_gain:      '0,
      target_code:  '0,
      drive_offset: '0,
      lock_window:  '0,
      rail_min:     16'h8000,
      rail_max:     16'h7FFF,
      int_min:      16'h8000,
      int_max:      16'h7FFF
   };

   typedef struct packed {
      op_type                   op;
      logic signed [DIFF_W-1:0] err;
      logic signed [PROD_W-1:0] p_err;
      logic signed [PROD_W-1:0] ki_err;
      logic        [SQ_W-1:0]   sq;
      logic                     locked;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== hdl/pcld_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcld_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [pcld_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [pcld_pkg::DATA_W-1:0]    pwdata,
   output logic      [pcld_pkg::DATA_W-1:0]    prdata,
   output logic                                pready,
   output pcld_pkg::cfg_type                   cfg
);

   localparam int CW = pcld_pkg::CODE_W;

   pcld_pkg::cfg_type       cfg_ff, cfg_in;
   pcld_pkg::reg_index_type idx;
   logic                    wr_en;

   assign idx    = pcld_pkg::reg_index_type'(paddr[pcld_pkg::ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            pcld_pkg::REG_P_GAIN:      cfg_in.p_gain       = pwdata;
            pcld_pkg::REG_KI_GAIN:     cfg_in.ki_gain      = pwdata;
            pcld_pkg::REG_KD_GAIN:     cfg_in.kd_gain      = pwdata;
            pcld_pkg::REG_TARGET:      cfg_in.target_code  = pwdata[CW-1:0];
            pcld_pkg::REG_OFFSET:      cfg_in.drive_offset = pwdata[CW-1:0];
            pcld_pkg::REG_LOCK_WINDOW: cfg_in.lock_window  = pwdata[CW-1:0];
            pcld_pkg::REG_RAILS: begin
               cfg_in.rail_min = pwdata[CW-1:0];
               cfg_in.rail_max = pwdata[2*CW-1:CW];
            end
            pcld_pkg::REG_INT_LIMITS: begin
               cfg_in.int_min = pwdata[CW-1:0];
               cfg_in.int_max = pwdata[2*CW-1:CW];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pcld_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read mux
   always_comb begin
      case (idx)
         pcld_pkg::REG_P_GAIN:      prdata = cfg_ff.p_gain;
         pcld_pkg::REG_KI_GAIN:     prdata = cfg_ff.ki_gain;
         pcld_pkg::REG_KD_GAIN:     prdata = cfg_ff.kd_gain;
         pcld_pkg::REG_TARGET:      prdata = {{(32-CW){1'b0}}, cfg_ff.target_code};
         pcld_pkg::REG_OFFSET:      prdata = {{(32-CW){1'b0}}, cfg_ff.drive_offset};
         pcld_pkg::REG_LOCK_WINDOW: prdata = {{(32-CW){1'b0}}, cfg_ff.lock_window};
         pcld_pkg::REG_RAILS:       prdata = {cfg_ff.rail_max, cfg_ff.rail_min};
         pcld_pkg::REG_INT_LIMITS:  prdata = {cfg_ff.int_max, cfg_ff.int_min};
         default:                   prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/pcld_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcld_front (
   input  wire logic                                  req_valid,
   input  wire logic signed [pcld_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                                  req_active,
   input  wire logic                                  req_restart,
   input  wire logic                                  req_clear_integral,
   output logic                                       req_stall,
   input  wire pcld_pkg::cfg_type                     cfg,
   input  wire pcld_pkg::q_status_type                q_status,
   output logic                                       push_valid,
   output pcld_pkg::q_entry_type                      push_data
);

   localparam int DW = pcld_pkg::DIFF_W;
   localparam int PW = pcld_pkg::PROD_W;

   logic signed [DW-1:0] err;
   logic        [DW-1:0] aerr;

   assign push_valid = req_valid;
   assign req_stall  = q_status.full;

   // error and the products that do not depend on loop state
   assign err  = DW'(cfg.target_code) - DW'(req_sample);
   assign aerr = err[DW-1] ? DW'(-err) : DW'(err);

   always_comb begin
      if (!req_active) begin
         push_data.op = pcld_pkg::OP_IDLE;
      end else if (req_restart) begin
         push_data.op = pcld_pkg::OP_RESTART;
      end else if (req_clear_integral) begin
         push_data.op = pcld_pkg::OP_CLEAR;
      end else begin
         push_data.op = pcld_pkg::OP_RUN;
      end
      push_data.err    = err;
      push_data.p_err  = PW'(cfg.p_gain) * PW'(err);
      push_data.ki_err = PW'(cfg.ki_gain) * PW'(err);
      push_data.sq     = pcld_pkg::SQ_W'(aerr) * pcld_pkg::SQ_W'(aerr);
      push_data.locked = DW'(cfg.lock_window) >= aerr;
   end

endmodule

`default_nettype wire

// ===== hdl/pcld_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcld_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   input  wire pcld_pkg::q_entry_type   push_data,
   input  wire logic                    pop_en,
   output pcld_pkg::q_entry_type        head,
   output pcld_pkg::q_status_type       q_status
);

   localparam int QD = pcld_pkg::QUEUE_DEPTH;
   localparam int PW = pcld_pkg::QPTR_W;
   localparam int CW = pcld_pkg::QCNT_W;

   pcld_pkg::q_entry_type entry_ff [QD];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign q_status.full  = (count_ff == CW'(QD));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop_en && !q_status.empty;
   assign head    = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QD - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QD - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pcld_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcld_back (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire pcld_pkg::cfg_type                      cfg,
   input  wire pcld_pkg::q_entry_type                  head,
   input  wire pcld_pkg::q_status_type                 q_status,
   output logic                                        pop_en,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [pcld_pkg::CODE_W-1:0]          rsp_drive,
   output logic                                        rsp_locked,
   output logic signed [pcld_pkg::ERR_BITS-1:0]        rsp_error_now,
   output logic signed [pcld_pkg::CODE_W-1:0]          rsp_integral_now,
   output logic signed [pcld_pkg::ERR_BITS-1:0]        rsp_error_peak_high,
   output logic signed [pcld_pkg::ERR_BITS-1:0]        rsp_error_peak_low,
   output logic        [pcld_pkg::CNT_W-1:0]           rsp_update_total,
   output logic        [pcld_pkg::SSUM_W-1:0]          rsp_squared_error_sum
);

   localparam int DW  = pcld_pkg::DIFF_W;
   localparam int DDW = pcld_pkg::DD_W;
   localparam int PW  = pcld_pkg::PROD_W;
   localparam int KW  = pcld_pkg::DPROD_W;
   localparam int AW  = pcld_pkg::ACC_W;
   localparam int IW  = pcld_pkg::ISUM_W;
   localparam int SW  = pcld_pkg::SUM_W;
   localparam int GF  = pcld_pkg::GAIN_FRAC_BITS;
   localparam int CW  = pcld_pkg::CODE_W;
   localparam int EW  = pcld_pkg::ERR_BITS;
   localparam int NW  = pcld_pkg::CNT_W;
   localparam int QW  = pcld_pkg::SSUM_W;

   // loop state
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [DW-1:0] prev_ff, prev_in;
   logic signed [DW-1:0] peak_hi_ff, peak_hi_in, peak_lo_ff, peak_lo_in;
   logic        [NW-1:0] cnt_ff, cnt_in;
   logic        [QW-1:0] sqsum_ff, sqsum_in;

   // working values at the queue head
   logic                 back_en, pop, run;
   logic signed [AW-1:0] base_acc;
   logic signed [DW-1:0] base_prev, base_hi, base_lo;
   logic        [NW-1:0] base_cnt;
   logic        [QW-1:0] base_sq;
   logic signed [IW-1:0] acc_sum, imax, imin, acc_sel;
   logic        [QW:0]   sq_tmp;

   // stage one
   logic                  s1_valid_ff, s1_active_ff, s1_locked_ff;
   logic signed [DW-1:0]  s1_err_ff, s1_hi_ff, s1_lo_ff;
   logic signed [DDW-1:0] s1_diff_ff;
   logic signed [PW-1:0]  s1_p_err_ff;
   logic signed [AW-1:0]  s1_acc_ff;
   logic        [NW-1:0]  s1_cnt_ff;
   logic        [QW-1:0]  s1_sq_ff;

   // stage two
   logic                  s2_valid_ff, s2_active_ff, s2_locked_ff;
   logic signed [DW-1:0]  s2_err_ff, s2_hi_ff, s2_lo_ff;
   logic signed [KW-1:0]  s2_kd_ff;
   logic signed [SW-1:0]  s2_part_ff;
   logic signed [AW-1:0]  s2_acc_ff;
   logic        [NW-1:0]  s2_cnt_ff;
   logic        [QW-1:0]  s2_sq_ff;

   // output stage
   logic                  rsp_valid_ff;
   logic signed [SW-1:0]  total, drv_shift, rmax, rmin;
   logic signed [CW-1:0]  drive_clamp;

   assign back_en = !rsp_valid_ff || !rsp_stall;
   assign pop     = back_en && !q_status.empty;
   assign pop_en  = pop;

   // item class sets the starting state of this update
   always_comb begin
      base_acc  = acc_ff;
      base_prev = prev_ff;
      base_hi   = peak_hi_ff;
      base_lo   = peak_lo_ff;
      base_cnt  = cnt_ff;
      base_sq   = sqsum_ff;
      run       = 1'b1;
      case (head.op)
         pcld_pkg::OP_IDLE: begin
            run = 1'b0;
         end
         pcld_pkg::OP_RUN: begin
            run = 1'b1;
         end
         pcld_pkg::OP_CLEAR: begin
            base_acc = '0;
         end
         pcld_pkg::OP_RESTART: begin
            base_acc  = '0;
            base_prev = '0;
            base_hi   = pcld_pkg::PEAK_HI_INIT;
            base_lo   = pcld_pkg::PEAK_LO_INIT;
            base_cnt  = '0;
            base_sq   = '0;
         end
         default: begin
            run = 1'b0;
         end
      endcase
   end

   // integral update and clamp, max is checked first
   assign acc_sum = IW'(base_acc) + IW'(head.ki_err);
   assign imax    = IW'(cfg.int_max) <<< GF;
   assign imin    = IW'(cfg.int_min) <<< GF;

   always_comb begin
      if (acc_sum > imax) begin
         acc_sel = imax;
      end else if (acc_sum < imin) begin
         acc_sel = imin;
      end else begin
         acc_sel = acc_sum;
      end
   end

   // saturating square sum
   assign sq_tmp = {1'b0, base_sq} + (QW + 1)'(head.sq);

   // next loop state
   always_comb begin
      acc_in     = acc_ff;
      prev_in    = prev_ff;
      peak_hi_in = peak_hi_ff;
      peak_lo_in = peak_lo_ff;
      cnt_in     = cnt_ff;
      sqsum_in   = sqsum_ff;
      if (pop && run) begin
         acc_in     = acc_sel[AW-1:0];
         prev_in    = head.err;
         peak_hi_in = (head.err > base_hi) ? head.err : base_hi;
         peak_lo_in = (head.err < base_lo) ? head.err : base_lo;
         cnt_in     = (&base_cnt) ? base_cnt : base_cnt + NW'(1);
         sqsum_in   = sq_tmp[QW] ? {QW{1'b1}} : sq_tmp[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         prev_ff    <= '0;
         peak_hi_ff <= pcld_pkg::PEAK_HI_INIT;
         peak_lo_ff <= pcld_pkg::PEAK_LO_INIT;
         cnt_ff     <= '0;
         sqsum_ff   <= '0;
      end else begin
         acc_ff     <= acc_in;
         prev_ff    <= prev_in;
         peak_hi_ff <= peak_hi_in;
         peak_lo_ff <= peak_lo_in;
         cnt_ff     <= cnt_in;
         sqsum_ff   <= sqsum_in;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // stage one: snapshot of the update and the derivative difference
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_active_ff <= run;
         s1_locked_ff <= head.locked;
         s1_err_ff    <= head.err;
         s1_diff_ff   <= DDW'(head.err) - DDW'(base_prev);
         s1_p_err_ff  <= head.p_err;
         s1_acc_ff    <= acc_in;
         s1_hi_ff     <= peak_hi_in;
         s1_lo_ff     <= peak_lo_in;
         s1_cnt_ff    <= cnt_in;
         s1_sq_ff     <= sqsum_in;
      end
   end

   // stage two: derivative product and partial drive sum
   always_ff @(posedge clock) begin
      if (back_en) begin
         s2_active_ff <= s1_active_ff;
         s2_locked_ff <= s1_locked_ff;
         s2_err_ff    <= s1_err_ff;
         s2_kd_ff     <= KW'(cfg.kd_gain) * KW'(s1_diff_ff);
         s2_part_ff   <= SW'(s1_p_err_ff) + SW'(s1_acc_ff) + (SW'(cfg.drive_offset) <<< GF);
         s2_acc_ff    <= s1_acc_ff;
         s2_hi_ff     <= s1_hi_ff;
         s2_lo_ff     <= s1_lo_ff;
         s2_cnt_ff    <= s1_cnt_ff;
         s2_sq_ff     <= s1_sq_ff;
      end
   end

   // round half up, then rail clamp with max checked first
   assign total     = s2_part_ff + SW'(s2_kd_ff) + pcld_pkg::ROUND_HALF;
   assign drv_shift = total >>> GF;
   assign rmax      = SW'(cfg.rail_max);
   assign rmin      = SW'(cfg.rail_min);

   always_comb begin
      if (drv_shift > rmax) begin
         drive_clamp = cfg.rail_max;
      end else if (drv_shift < rmin) begin
         drive_clamp = cfg.rail_min;
      end else begin
         drive_clamp = drv_shift[CW-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (back_en) begin
         rsp_drive             <= s2_active_ff ? drive_clamp : '0;
         rsp_locked            <= s2_active_ff && s2_locked_ff;
         rsp_error_now         <= s2_active_ff ? s2_err_ff[EW-1:0] : '0;
         rsp_integral_now      <= s2_acc_ff[GF+CW-1:GF];
         rsp_error_peak_high   <= s2_hi_ff[EW-1:0];
         rsp_error_peak_low    <= s2_lo_ff[EW-1:0];
         rsp_update_total      <= s2_cnt_ff;
         rsp_squared_error_sum <= s2_sq_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // update count only drops on a restart
   a_cnt_mono: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$past(pop && head.op == pcld_pkg::OP_RESTART))
         |-> (cnt_ff >= $past(cnt_ff)))
      else $error("update count fell without restart");

   // square sum only drops on a restart
   a_sq_mono: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$past(pop && head.op == pcld_pkg::OP_RESTART))
         |-> (sqsum_ff >= $past(sqsum_ff)))
      else $error("square sum fell without restart");

   // once any update ran the peaks are ordered
   a_peak_order: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (peak_lo_ff <= peak_hi_ff))
      else $error("error peaks out of order");

   // loop state moves only when an item leaves the queue
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$past(pop)) |-> ($stable(acc_ff) && $stable(prev_ff)))
      else $error("loop state changed without an item");

endmodule

`default_nettype wire

// ===== hdl/pid_clamped_lock_detect.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  sample, active, restart, clear_integral
// rsp_      out        rsp_valid/rsp_stall  drive, locked, error_now, integral_now,
//                                           peaks, update_total, squared_error_sum
// csr       in         psel/penable/pready  8 registers at byte address 4*i
//
// one item per cycle while rsp_stall is low; items pass s1, s2 and the output reg
// integral and previous error close their loop at the queue head
// reset is synchronous and active high; config regs return to their defaults
// a stalled result holds the back pipeline; the 4-entry queue absorbs new items
// and req_stall rises only when that queue is full

module pid_clamped_lock_detect (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [pcld_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                                   req_active,
   input  wire logic                                   req_restart,
   input  wire logic                                   req_clear_integral,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [pcld_pkg::CODE_W-1:0]          rsp_drive,
   output logic                                        rsp_locked,
   output logic signed [pcld_pkg::ERR_BITS-1:0]        rsp_error_now,
   output logic signed [pcld_pkg::CODE_W-1:0]          rsp_integral_now,
   output logic signed [pcld_pkg::ERR_BITS-1:0]        rsp_error_peak_high,
   output logic signed [pcld_pkg::ERR_BITS-1:0]        rsp_error_peak_low,
   output logic        [pcld_pkg::CNT_W-1:0]           rsp_update_total,
   output logic        [pcld_pkg::SSUM_W-1:0]          rsp_squared_error_sum,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [pcld_pkg::ADDR_W-1:0]            paddr,
   input  wire logic [pcld_pkg::DATA_W-1:0]            pwdata,
   output logic      [pcld_pkg::DATA_W-1:0]            prdata,
   output logic                                        pready
);

   pcld_pkg::cfg_type      cfg;
   pcld_pkg::q_status_type q_status;
   pcld_pkg::q_entry_type  push_data, head;
   logic                   push_valid, pop_en;

   // configuration registers
   pcld_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // accept and classify
   pcld_front u_front (
      .req_valid          (req_valid),
      .req_sample         (req_sample),
      .req_active         (req_active),
      .req_restart        (req_restart),
      .req_clear_integral (req_clear_integral),
      .req_stall          (req_stall),
      .cfg                (cfg),
      .q_status           (q_status),
      .push_valid         (push_valid),
      .push_data          (push_data)
   );

   // queue between front and back
   pcld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_en     (pop_en),
      .head       (head),
      .q_status   (q_status)
   );

   // loop update and drive pipeline
   pcld_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .head                  (head),
      .q_status              (q_status),
      .pop_en                (pop_en),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_drive             (rsp_drive),
      .rsp_locked            (rsp_locked),
      .rsp_error_now         (rsp_error_now),
      .rsp_integral_now      (rsp_integral_now),
      .rsp_error_peak_high   (rsp_error_peak_high),
      .rsp_error_peak_low    (rsp_error_peak_low),
      .rsp_update_total      (rsp_update_total),
      .rsp_squared_error_sum (rsp_squared_error_sum)
   );

endmodule

`default_nettype wire
